[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: label");
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed: label");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_RST(label, clk, rst_n, prop)
`endif
`endif

[rtl/fadd_pkg.sv]
// ---------------------------------------------------------------------------
// fadd_pkg
// Shared constants for the truncating single-precision adder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package fadd_pkg;
    localparam int unsigned NumStages = 4;
    localparam logic [22:0] HiddenOne = 23'h400000;
    localparam int unsigned LeadPos = 22;
    localparam logic FuncAdd = 1'b0;
    localparam logic FuncSub = 1'b1;
endpackage

[rtl/float32_add_sub_truncating.sv]
// ---------------------------------------------------------------------------
// float32_add_sub_truncating
// Truncating single-precision add/subtract, four-stage pipeline.
// ---------------------------------------------------------------------------
// Pipeline: four register stages; m_tvalid rises once the input transfer
// has passed through stages 1 to 3 and into the output register.
// Throughput: one transfer per cycle; the pipeline advances whenever the
// output register is empty or being taken, so a stall holds every stage.
// Reset: rst_n clears all stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module float32_add_sub_truncating
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [0] func, [32:1] a_bits, [64:33] b_bits, [71:65] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] sum_bits
);
    logic [fadd_pkg::NumStages-1:0] vld_reg;
    logic advance;

    // Whole pipe moves together; the last stage is the output register.
    assign advance  = !vld_reg[fadd_pkg::NumStages-1] || m_tready;
    assign s_tready = advance;
    assign m_tvalid = vld_reg[fadd_pkg::NumStages-1];

    // ---------------- stage 1: unpack, zero bypass, exponent compare -------
    logic        f_in;
    logic [31:0] a_in, b_in;
    logic        byp_next;
    logic [31:0] byp_val_next;
    logic        a_big_next;
    logic [7:0]  base_next, diff_next;
    logic [22:0] bigm_next, smlm_next;
    logic        sbig_next, ssml_next;
    logic [7:0]  ea, eb;
    logic [22:0] xm, ym;

    always_comb
    begin
        f_in = s_tdata[0];
        a_in = s_tdata[32:1];
        b_in = s_tdata[64:33];
        if (f_in == fadd_pkg::FuncSub)
        begin
            b_in[31] = ~b_in[31];
        end
        ea = a_in[30:23];
        eb = b_in[30:23];
        xm = {1'b0, a_in[22:1]} + fadd_pkg::HiddenOne;
        ym = {1'b0, b_in[22:1]} + fadd_pkg::HiddenOne;
        byp_next = 1'b0;
        byp_val_next = a_in;
        if (b_in[30:0] == 31'd0)
        begin
            byp_next = 1'b1;
            byp_val_next = a_in;
        end
        else if (a_in[30:0] == 31'd0)
        begin
            byp_next = 1'b1;
            byp_val_next = b_in;
        end
        a_big_next = ea > eb;
        // Larger-exponent operand is "big"; on equal exponents b is big.
        if (a_big_next)
        begin
            base_next = ea; diff_next = ea - eb;
            bigm_next = xm; smlm_next = ym;
            sbig_next = a_in[31]; ssml_next = b_in[31];
        end
        else
        begin
            base_next = eb; diff_next = eb - ea;
            bigm_next = ym; smlm_next = xm;
            sbig_next = b_in[31]; ssml_next = a_in[31];
        end
    end

    logic        s1_byp_reg;
    logic [31:0] s1_bval_reg;
    logic        s1_abig_reg, s1_sbig_reg, s1_ssml_reg;
    logic [7:0]  s1_base_reg, s1_diff_reg;
    logic [22:0] s1_bigm_reg, s1_smlm_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_byp_reg  <= byp_next;
            s1_bval_reg <= byp_val_next;
            s1_abig_reg <= a_big_next;
            s1_sbig_reg <= sbig_next;
            s1_ssml_reg <= ssml_next;
            s1_base_reg <= base_next;
            s1_diff_reg <= diff_next;
            s1_bigm_reg <= bigm_next;
            s1_smlm_reg <= smlm_next;
        end
    end

    // ---------------- stage 2: align, add or subtract, sign ----------------
    logic [22:0] alm;
    logic [23:0] zm_next;
    logic        sz_next;
    logic        sa2, sb2;
    logic [22:0] xa, ya;

    always_comb
    begin
        // Shifts of 23 or more clear the 23-bit mantissa, covering >= 32.
        alm = (s1_diff_reg > 8'd22) ? 23'd0 : (s1_smlm_reg >> s1_diff_reg[4:0]);
        if (s1_abig_reg)
        begin
            xa = s1_bigm_reg; ya = alm; sa2 = s1_sbig_reg; sb2 = s1_ssml_reg;
        end
        else
        begin
            xa = alm; ya = s1_bigm_reg; sa2 = s1_ssml_reg; sb2 = s1_sbig_reg;
        end
        if (sa2 == sb2)
        begin
            zm_next = {1'b0, xa} + {1'b0, ya};
            sz_next = sa2;
        end
        else if (xa > ya)
        begin
            zm_next = {1'b0, xa - ya};
            sz_next = sa2;
        end
        else
        begin
            zm_next = {1'b0, ya - xa};
            sz_next = sb2;
        end
    end

    logic        s2_byp_reg, s2_sz_reg;
    logic [31:0] s2_bval_reg;
    logic [7:0]  s2_base_reg;
    logic [23:0] s2_zm_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_byp_reg  <= s1_byp_reg;
            s2_bval_reg <= s1_bval_reg;
            s2_sz_reg   <= sz_next;
            s2_base_reg <= s1_base_reg;
            s2_zm_reg   <= zm_next;
        end
    end

    // ---------------- stage 3: leading-one search --------------------------
    logic [4:0] lead_next;

    always_comb
    begin
        lead_next = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (s2_zm_reg[i])
            begin
                lead_next = 5'(i);
            end
        end
    end

    logic        s3_byp_reg, s3_sz_reg;
    logic [31:0] s3_bval_reg;
    logic [7:0]  s3_base_reg;
    logic [23:0] s3_zm_reg;
    logic [4:0]  s3_lead_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_byp_reg  <= s2_byp_reg;
            s3_bval_reg <= s2_bval_reg;
            s3_sz_reg   <= s2_sz_reg;
            s3_base_reg <= s2_base_reg;
            s3_zm_reg   <= s2_zm_reg;
            s3_lead_reg <= lead_next;
        end
    end

    // ---------------- stage 4: normalize, pack -----------------------------
    logic [31:0] res_next;
    logic [22:0] mant;
    logic [24:0] zx;
    logic [7:0]  ez;

    always_comb
    begin
        zx = {s3_zm_reg, 1'b0};
        // Keep the 23 bits of zx below its leading one, shifting that one up to bit 23 if lower.
        if (s3_lead_reg == 5'(fadd_pkg::LeadPos + 1))
        begin
            mant = zx[23:1];
        end
        else
        begin
            mant = 23'(zx << (5'(fadd_pkg::LeadPos) - s3_lead_reg));
        end
        ez = s3_base_reg + 8'(s3_lead_reg) - 8'(fadd_pkg::LeadPos);
        if (s3_byp_reg)
        begin
            res_next = s3_bval_reg;
        end
        else if (s3_zm_reg == 24'd0)
        begin
            res_next = 32'd0;
        end
        else
        begin
            res_next = {s3_sz_reg, ez, mant};
        end
    end

    logic [31:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res_next;
        end
    end
    assign m_tdata = out_reg;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[fadd_pkg::NumStages-2:0], s_tvalid};
        end
    end

    `ASSERT_IMPL(a_stall_holds, clk, rst_n, (m_tvalid && !m_tready) |=> $stable(m_tdata))
    `ASSERT_IMPL(a_no_accept_on_stall, clk, rst_n, (m_tvalid && !m_tready) |-> !s_tready)
    `ASSERT_IMPL(a_stage_flow, clk, rst_n, (advance && vld_reg[2]) |=> m_tvalid)
    `ASSERT_RST(a_reset_empty, clk, rst_n, !rst_n |=> (vld_reg == '0) || !rst_n)

endmodule

[bench/float32_add_sub_truncating_tb.sv]
// ---------------------------------------------------------------------------
// float32_add_sub_truncating_tb
// Self-checking bench for the truncating single-precision add/subtract unit.
// Each transfer is predicted in the bench and the results are checked in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module float32_add_sub_truncating_tb;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // [0] func, [32:1] a_bits, [64:33] b_bits, [71:65] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] sum_bits

    logic [31:0] sum_queue[$];
    int          errors;
    int          cycles;
    int          sent;
    int          checked;
    bit          quiet_sink;
    bit          quiet_src;

    localparam int CycleLimit = 200000;

    float32_add_sub_truncating dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Truncating add: drop the low mantissa bit, align, add or subtract,
    // renormalize on the leading one, wrap the exponent modulo 256.
    function automatic logic [31:0] predict_sum(logic op, logic [31:0] a, logic [31:0] b);
        logic [31:0] xm;
        logic [31:0] ym;
        logic [31:0] zm;
        logic [31:0] mant;
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [7:0]  base;
        logic [7:0]  sh;
        logic        sz;
        int          lead;
        int          h;
        if (op == fadd_pkg::FuncSub)
            b[31] = ~b[31];
        if (b[30:0] == 31'd0)
            return a;
        if (a[30:0] == 31'd0)
            return b;
        ea = a[30:23];
        eb = b[30:23];
        xm = {10'd0, a[22:1]} + {9'd0, fadd_pkg::HiddenOne};
        ym = {10'd0, b[22:1]} + {9'd0, fadd_pkg::HiddenOne};
        if (ea > eb)
        begin
            sh = ea - eb;
            ym = (sh >= 32) ? 32'd0 : (ym >> sh);
            base = ea;
        end
        else
        begin
            sh = eb - ea;
            xm = (sh >= 32) ? 32'd0 : (xm >> sh);
            base = eb;
        end
        if (a[31] == b[31])
        begin
            zm = xm + ym;
            sz = a[31];
        end
        else if (xm > ym)
        begin
            zm = xm - ym;
            sz = a[31];
        end
        else
        begin
            zm = ym - xm;
            sz = b[31];
        end
        // Exact cancellation gives plus zero.
        if (zm == 32'd0)
            return 32'd0;
        lead = 0;
        for (int p = 0; p < 32; p++)
            if (zm[p])
                lead = p;
        h = lead - int'(fadd_pkg::LeadPos);
        if (h >= 0)
            mant = (zm << 1) >> h;
        else
            mant = (zm << 1) << (-h);
        return {sz, 8'(base + 8'(h)), mant[22:0]};
    endfunction

    // Hold each transfer until it is taken; idle now and then in between.
    task automatic send_op(logic op, logic [31:0] a, logic [31:0] b);
        while (!quiet_src && $urandom_range(0, 99) < 12)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, b, a, op};
        sum_queue.push_back(predict_sum(op, a, b));
        sent++;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: v[30:23] = 8'($urandom_range(120, 134));
            1: v[30:0]  = 31'd0;
            2: v[30:23] = 8'($urandom_range(0, 3)) ^ {8{v[0]}};
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_zero_operands();
        send_op(fadd_pkg::FuncAdd, 32'h3F80_0000, 32'h0000_0000);
        send_op(fadd_pkg::FuncAdd, 32'h3F80_0000, 32'h8000_0000);
        send_op(fadd_pkg::FuncSub, 32'h8000_0000, 32'h4040_0000);
        send_op(fadd_pkg::FuncAdd, 32'h0000_0000, 32'hC120_0000);
        send_op(fadd_pkg::FuncSub, 32'h0000_0000, 32'h8000_0000);
    endtask

    task automatic test_extremes();
        send_op(fadd_pkg::FuncAdd, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(fadd_pkg::FuncSub, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_op(fadd_pkg::FuncAdd, 32'h7F80_0000, 32'h7FC0_0001);
        send_op(fadd_pkg::FuncAdd, 32'h0000_0001, 32'h0000_0003);
        send_op(fadd_pkg::FuncAdd, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
        send_op(fadd_pkg::FuncSub, 32'h0080_0000, 32'h0000_0001);
    endtask

    task automatic test_alignment_and_sign();
        send_op(fadd_pkg::FuncSub, 32'h3F80_0000, 32'h3F80_0000);
        send_op(fadd_pkg::FuncAdd, 32'h3F80_0000, 32'hBF80_0001);
        send_op(fadd_pkg::FuncAdd, 32'h3F80_0000, 32'h3F80_0000);
        send_op(fadd_pkg::FuncAdd, 32'h4F80_0000, 32'h3F80_0000);
        send_op(fadd_pkg::FuncAdd, 32'h3F80_0000, 32'h4F80_0000);
        send_op(fadd_pkg::FuncAdd, 32'h3F80_0000, 32'h4E80_0000);
        send_op(fadd_pkg::FuncSub, 32'h4000_0000, 32'h3FFF_FFFE);
        send_op(fadd_pkg::FuncSub, 32'h3FFF_FFFE, 32'h4000_0000);
        send_op(fadd_pkg::FuncAdd, 32'h4120_0000, 32'hC11F_FFFF);
    endtask

    task automatic test_random();
        for (int i = 0; i < 600; i++)
        begin
            quiet_src = (i >= 250 && i < 350);
            send_op(1'($urandom), rand_float(), rand_float());
        end
        quiet_src = 1'b0;
    endtask

    // Sink side: stall at random except in the quiet stretch.
    always @(negedge clk)
        if (rst_n)
            m_tready <= quiet_sink || ($urandom_range(0, 99) >= 12);

    always @(posedge clk)
    begin
        cycles++;
        quiet_sink <= (sent >= 250 && sent < 350);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sum_queue.size() == 0)
            begin
                $error("sum_bits: unexpected result %h", m_tdata);
                errors++;
            end
            else
            begin
                if (m_tdata !== sum_queue[0])
                begin
                    $error("sum_bits: expected %h actual %h", sum_queue[0], m_tdata);
                    errors++;
                end
                void'(sum_queue.pop_front());
                checked++;
            end
        end
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** float32_add_sub_truncating: FAILED **");
            $finish;
        end
    end

    initial
    begin
        errors     = 0;
        cycles     = 0;
        sent       = 0;
        checked    = 0;
        quiet_sink = 1'b0;
        quiet_src  = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        test_zero_operands();
        test_extremes();
        test_alignment_and_sign();
        test_random();
        s_tvalid <= 1'b0;
        while (sum_queue.size() != 0)
            @(posedge clk);
        repeat (4 * fadd_pkg::NumStages) @(posedge clk);
        $display("sent %0d add/sub transfers, checked %0d results", sent, checked);
        $display("covered zero operands, extremes, alignment, cancellation, random mix");
        if (errors == 0 && sum_queue.size() == 0)
            $display("** float32_add_sub_truncating: PASSED **");
        else
            $display("** float32_add_sub_truncating: FAILED **");
        $finish;
    end
endmodule
